/* rtl/plrm_pkg.sv */
package plrm_pkg;

   // request codes
   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_DEL  = 2'd1;
   localparam logic [1:0] REQ_EVAL = 2'd2;

   // result status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_DUP       = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   // evaluate verdicts
   localparam logic [1:0] VERD_NONE   = 2'd0;
   localparam logic [1:0] VERD_PERMIT = 2'd1;
   localparam logic [1:0] VERD_DENY   = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_DECIDE,
      OP_SHIFT,
      OP_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } plrm_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic move_done;
      logic do_move;
      logic do_write;
      logic is_add;
   } plrm_sts_type;

endpackage

/* rtl/plrm_dpath.sv */
module plrm_dpath import plrm_pkg::*; #(
   parameter int MAX_RULES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  plrm_cmd_type       cmd,
   output plrm_sts_type       sts,
   input  logic               csr_we,
   input  logic [15:0]        csr_data,
   input  logic [1:0]         req_type,
   input  logic [31:0]        req_seq_no,
   input  logic               req_action,
   input  logic [31:0]        req_prefix,
   input  logic [5:0]         req_prefix_len,
   input  logic signed [6:0]  req_min_len,
   input  logic signed [6:0]  req_max_len,
   output logic [1:0]         rsp_status,
   output logic [1:0]         rsp_verdict,
   output logic [31:0]        rsp_rule_seq,
   output logic [31:0]        rsp_rule_hit_count
);

   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] prefix;
      logic [5:0]  plen;
      logic [6:0]  ge;
      logic [6:0]  le;
      logic        deny;
      logic [31:0] hits;
   } entry_type;

   entry_type rules_ff [MAX_RULES];
   entry_type rd_data_ff;

   // control
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      auto_seq_ff, auto_seq_in;
   logic [15:0]      seq_step_ff, seq_step_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] mv_left_ff, mv_left_in;
   logic             found_ff, found_in;
   logic             pos_set_ff, pos_set_in;

   // request and result payload
   logic [1:0]       type_ff, type_in;
   logic [31:0]      seq_ff, seq_in;
   logic             auto_ff, auto_in;
   logic             deny_ff, deny_in;
   logic [31:0]      prefix_ff, prefix_in;
   logic [5:0]       plen_ff, plen_in;
   logic [6:0]       ge_ff, ge_in;
   logic [6:0]       le_ff, le_in;
   logic [CNT_W-1:0] data_idx_ff, data_idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   entry_type        hold_ff, hold_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [1:0]       res_verdict_ff, res_verdict_in;
   logic [31:0]      res_seq_ff, res_seq_in;
   logic [31:0]      res_hits_ff, res_hits_in;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       rsp_verdict_ff;
   logic [31:0]      rsp_seq_ff;
   logic [31:0]      rsp_hits_ff;

   // memory port
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [CNT_W-1:0] wr_idx;

   // compare of the entry read last cycle
   entry_type        e;
   logic signed [7:0] plen_s;
   logic signed [7:0] ge_s;
   logic signed [7:0] le_s;
   logic [31:0]      mask;
   logic             rule_hit;
   logic             dup_hit;
   logic             hit;
   logic             proc;
   logic             match_now;
   logic             full;
   logic             issue;

   assign e      = rd_data_ff;
   assign plen_s = signed'({2'b00, plen_ff});
   assign ge_s   = signed'({e.ge[6], e.ge});
   assign le_s   = signed'({e.le[6], e.le});
   assign mask   = (e.plen >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> e.plen[4:0]);

   // negative le means no upper bound
   assign rule_hit = (plen_s >= ge_s) && (e.le[6] || (plen_s <= le_s))
                     && (((prefix_ff ^ e.prefix) & mask) == 32'd0);
   assign dup_hit  = (e.prefix == prefix_ff) && (e.plen == plen_ff)
                     && (e.ge == ge_ff) && (e.le == le_ff);

   always_comb begin
      case (type_ff)
         REQ_ADD:  hit = dup_hit;
         REQ_DEL:  hit = (e.seq == seq_ff);
         REQ_EVAL: hit = rule_hit;
         default:  hit = 1'b0;
      endcase
   end

   assign proc      = (cmd.op == OP_SCAN) && rd_vld_ff && !found_ff;
   assign match_now = proc && hit;
   assign full      = (count_ff == CNT_W'(MAX_RULES));

   assign sts.scan_done = found_ff || (!rd_vld_ff && (rd_idx_ff == count_ff));
   assign sts.move_done = (mv_left_ff == '0) && !rd_vld_ff;
   assign sts.do_move   = ((type_ff == REQ_ADD) && !found_ff && !full)
                          || ((type_ff == REQ_DEL) && found_ff);
   assign sts.do_write  = (type_ff == REQ_EVAL) && found_ff;
   assign sts.is_add    = (type_ff == REQ_ADD);

   always_comb begin
      count_in       = count_ff;
      auto_seq_in    = auto_seq_ff;
      seq_step_in    = csr_we ? csr_data : seq_step_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = 1'b0;
      mv_left_in     = mv_left_ff;
      found_in       = found_ff;
      pos_set_in     = pos_set_ff;
      type_in        = type_ff;
      seq_in         = seq_ff;
      auto_in        = auto_ff;
      deny_in        = deny_ff;
      prefix_in      = prefix_ff;
      plen_in        = plen_ff;
      ge_in          = ge_ff;
      le_in          = le_ff;
      data_idx_in    = data_idx_ff;
      pos_in         = pos_ff;
      hold_in        = hold_ff;
      res_status_in  = res_status_ff;
      res_verdict_in = res_verdict_ff;
      res_seq_in     = res_seq_ff;
      res_hits_in    = res_hits_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_idx         = pos_ff;
      wr_data        = hold_ff;
      issue          = 1'b0;

      case (cmd.op)
         OP_LOAD: begin
            type_in   = req_type;
            auto_in   = (req_type == REQ_ADD) && (req_seq_no == 32'd0);
            seq_in    = auto_in ? (auto_seq_ff + {16'd0, seq_step_ff}) : req_seq_no;
            deny_in   = req_action;
            prefix_in = req_prefix;
            plen_in   = req_prefix_len;
            ge_in     = (req_min_len == -7'sd1) ? {1'b0, req_prefix_len} : req_min_len;
            le_in     = (req_max_len == -7'sd1) ? {1'b0, req_prefix_len} : req_max_len;
            rd_idx_in      = '0;
            found_in       = 1'b0;
            pos_set_in     = 1'b0;
            pos_in         = count_ff;
            res_status_in  = STS_OK;
            res_verdict_in = VERD_NONE;
            res_seq_in     = 32'd0;
            res_hits_in    = 32'd0;
         end
         OP_SCAN: begin
            if (proc) begin
               if (hit) begin
                  found_in     = 1'b1;
                  pos_in       = data_idx_ff;
                  hold_in      = e;
                  hold_in.hits = e.hits + 32'd1;
               end else if ((type_ff == REQ_ADD) && !pos_set_ff && (e.seq > seq_ff)) begin
                  // first rule with a larger sequence is the insert point
                  pos_in     = data_idx_ff;
                  pos_set_in = 1'b1;
               end
            end
            issue       = (rd_idx_ff < count_ff) && !found_ff && !match_now;
            rd_en       = issue;
            rd_vld_in   = issue;
            data_idx_in = rd_idx_ff;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
         end
         OP_DECIDE: begin
            case (type_ff)
               REQ_ADD: begin
                  if (found_ff) begin
                     res_status_in = STS_DUP;
                  end else if (full) begin
                     res_status_in = STS_FULL;
                  end else begin
                     res_seq_in = seq_ff;
                     if (auto_ff) begin
                        auto_seq_in = seq_ff;
                     end
                     rd_idx_in  = count_ff - CNT_W'(1);
                     mv_left_in = count_ff - pos_ff;
                  end
               end
               REQ_DEL: begin
                  if (found_ff) begin
                     res_seq_in = seq_ff;
                     rd_idx_in  = pos_ff + CNT_W'(1);
                     mv_left_in = count_ff - pos_ff - CNT_W'(1);
                     count_in   = count_ff - CNT_W'(1);
                  end else begin
                     res_status_in = STS_NOT_FOUND;
                  end
               end
               REQ_EVAL: begin
                  if (found_ff) begin
                     res_verdict_in = hold_ff.deny ? VERD_DENY : VERD_PERMIT;
                     res_seq_in     = hold_ff.seq;
                     res_hits_in    = hold_ff.hits;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_SHIFT: begin
            // insert moves entries up from the top, delete moves them down
            issue       = (mv_left_ff != '0);
            rd_en       = issue;
            rd_vld_in   = issue;
            data_idx_in = rd_idx_ff;
            if (issue) begin
               mv_left_in = mv_left_ff - CNT_W'(1);
               rd_idx_in  = (type_ff == REQ_ADD) ? (rd_idx_ff - CNT_W'(1))
                                                 : (rd_idx_ff + CNT_W'(1));
            end
            wr_en   = rd_vld_ff;
            wr_idx  = (type_ff == REQ_ADD) ? (data_idx_ff + CNT_W'(1))
                                           : (data_idx_ff - CNT_W'(1));
            wr_data = rd_data_ff;
         end
         OP_WRITE: begin
            wr_en  = 1'b1;
            wr_idx = pos_ff;
            if (type_ff == REQ_ADD) begin
               wr_data.seq    = seq_ff;
               wr_data.prefix = prefix_ff;
               wr_data.plen   = plen_ff;
               wr_data.ge     = ge_ff;
               wr_data.le     = le_ff;
               wr_data.deny   = deny_ff;
               wr_data.hits   = 32'd0;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_addr = wr_idx[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rules_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rules_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         auto_seq_ff <= 32'd0;
         seq_step_ff <= 16'd5;
         rd_idx_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         mv_left_ff  <= '0;
         found_ff    <= 1'b0;
         pos_set_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         auto_seq_ff <= auto_seq_in;
         seq_step_ff <= seq_step_in;
         rd_idx_ff   <= rd_idx_in;
         rd_vld_ff   <= rd_vld_in;
         mv_left_ff  <= mv_left_in;
         found_ff    <= found_in;
         pos_set_ff  <= pos_set_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      seq_ff         <= seq_in;
      auto_ff        <= auto_in;
      deny_ff        <= deny_in;
      prefix_ff      <= prefix_in;
      plen_ff        <= plen_in;
      ge_ff          <= ge_in;
      le_ff          <= le_in;
      data_idx_ff    <= data_idx_in;
      pos_ff         <= pos_in;
      hold_ff        <= hold_in;
      res_status_ff  <= res_status_in;
      res_verdict_ff <= res_verdict_in;
      res_seq_ff     <= res_seq_in;
      res_hits_ff    <= res_hits_in;
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_verdict_ff <= res_verdict_ff;
         rsp_seq_ff     <= res_seq_ff;
         rsp_hits_ff    <= res_hits_ff;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_rule_seq       = rsp_seq_ff;
   assign rsp_rule_hit_count = rsp_hits_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count above table depth");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_WRITE) && (type_ff == REQ_ADD)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("add did not grow the table");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DECIDE) && found_ff && ((type_ff == REQ_DEL) || (type_ff == REQ_EVAL))
      |-> pos_ff < count_ff)
      else $error("matched slot outside stored rules");

endmodule

/* rtl/plrm_ctrl.sv */
module plrm_ctrl import plrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output plrm_cmd_type cmd,
   input  plrm_sts_type sts
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_SHIFT  = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.op = OP_DECIDE;
            if (sts.do_move) begin
               state_in = ST_SHIFT;
            end else if (sts.do_write) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            cmd.op = OP_SHIFT;
            if (sts.move_done) begin
               state_in = sts.is_add ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // output slot is free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("result load did not finish the request");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

endmodule

/* rtl/prefix_list_rule_matcher.sv */
// IPv4 prefix-list filter with ge/le bounds, up to MAX_RULES rules kept in
// ascending sequence order in a single-port-read rule memory.
// req channel: req_valid/req_stall, one request per handshake: add rule,
//   delete by sequence, or evaluate a prefix. one request is worked at a time;
//   req_stall is high from acceptance until its result is handed to the
//   output register.
// rsp channel: rsp_valid/rsp_stall, one result per request. the output
//   register holds a finished result while rsp_stall is high, and the next
//   request is already accepted and worked meanwhile; only its hand-off waits.
// csr channel: csr_valid/csr_ready writes seq_step (csr_ready is always high);
//   write it only while no request is in flight.
// request flow: the scan reads one rule per cycle until a match or the last
//   stored rule. add also moves the rules behind its slot one per cycle;
//   delete moves only the rules behind the found slot. the controller is
//   back in idle and accepts the next request the cycle after the result is
//   loaded. the memory read port sets the pace of the scan and the moves.
// reset clears the rule count (table empty), the auto sequence counter and
//   the output valid, and sets seq_step to 5; no clearing pass is needed.
module prefix_list_rule_matcher import plrm_pkg::*; #(
   parameter int MAX_RULES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [31:0]       req_seq_no,
   input  logic              req_action,
   input  logic [31:0]       req_prefix,
   input  logic [5:0]        req_prefix_len,
   input  logic signed [6:0] req_min_len,
   input  logic signed [6:0] req_max_len,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_verdict,
   output logic [31:0]       rsp_rule_seq,
   output logic [31:0]       rsp_rule_hit_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   plrm_cmd_type cmd;
   plrm_sts_type sts;
   logic         csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   plrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   plrm_dpath #(
      .MAX_RULES (MAX_RULES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_data           (csr_data),
      .req_type           (req_type),
      .req_seq_no         (req_seq_no),
      .req_action         (req_action),
      .req_prefix         (req_prefix),
      .req_prefix_len     (req_prefix_len),
      .req_min_len        (req_min_len),
      .req_max_len        (req_max_len),
      .rsp_status         (rsp_status),
      .rsp_verdict        (rsp_verdict),
      .rsp_rule_seq       (rsp_rule_seq),
      .rsp_rule_hit_count (rsp_rule_hit_count)
   );

endmodule
